[hdl/m68kd_pkg.sv]
// Shared types, codes and a helper function of the 68000 opcode decoder.
package m68kd_pkg;

  typedef enum logic [3:0] {
    FORM_NONE     = 4'd0,
    FORM_PAIR     = 4'd1,
    FORM_SRC      = 4'd2,
    FORM_DST      = 4'd3,
    FORM_QDST     = 4'd4,
    FORM_QONLY    = 4'd5,
    FORM_FROM_SR  = 4'd6,
    FORM_FROM_CCR = 4'd7,
    FORM_TO_SR    = 4'd8,
    FORM_TO_CCR   = 4'd9,
    FORM_TO_USP   = 4'd10,
    FORM_FROM_USP = 4'd11,
    FORM_BR       = 4'd12,
    FORM_DBR      = 4'd13,
    FORM_XFIRST   = 4'd14,
    FORM_XLAST    = 4'd15
  } form_e;

  localparam logic [6:0] MN_NONE = 7'd0, MN_ORI = 7'd1, MN_ANDI = 7'd2, MN_SUBI = 7'd3,
    MN_ADDI = 7'd4, MN_EORI = 7'd5, MN_CMPI = 7'd6, MN_MOVES = 7'd7, MN_BTST = 7'd8,
    MN_MOVEP = 7'd12, MN_MOVE = 7'd13, MN_MOVEA = 7'd14, MN_NEGX = 7'd15, MN_CLR = 7'd16,
    MN_NEG = 7'd17, MN_NOT = 7'd18, MN_TST = 7'd19, MN_TAS = 7'd20, MN_ILLEGAL = 7'd21,
    MN_NBCD = 7'd22, MN_SWAP = 7'd23, MN_PEA = 7'd24, MN_EXT = 7'd25, MN_MOVEM = 7'd26,
    MN_LEA = 7'd27, MN_CHK = 7'd28, MN_TRAP = 7'd29, MN_LINK = 7'd30, MN_UNLK = 7'd31,
    MN_RESET = 7'd32, MN_MOVEC = 7'd40, MN_JSR = 7'd41, MN_JMP = 7'd42, MN_ADDQ = 7'd43,
    MN_SUBQ = 7'd44, MN_SCC = 7'd45, MN_DBCC = 7'd46, MN_BRA = 7'd47, MN_BSR = 7'd48,
    MN_BCC = 7'd49, MN_MOVEQ = 7'd50, MN_OR = 7'd51, MN_DIVU = 7'd52, MN_DIVS = 7'd53,
    MN_SUB = 7'd54, MN_SUBA = 7'd55, MN_CMP = 7'd56, MN_CMPA = 7'd57, MN_EOR = 7'd58,
    MN_AND = 7'd59, MN_MULU = 7'd60, MN_MULS = 7'd61, MN_ADD = 7'd62, MN_ADDA = 7'd63,
    MN_SBCD = 7'd64, MN_SUBX = 7'd65, MN_ABCD = 7'd66, MN_EXG = 7'd67, MN_ADDX = 7'd68,
    MN_CMPM = 7'd69, MN_ASR = 7'd70;

  localparam logic [1:0] SZ_BYTE = 2'd0, SZ_WORD = 2'd1, SZ_LONG = 2'd2, SZ_NONE = 2'd3;

  typedef struct packed {
    logic [6:0]  mnemonic;
    logic [1:0]  size_code;
    form_e       operand_form;
    logic [2:0]  src_mode;
    logic [2:0]  src_reg;
    logic [2:0]  dst_mode;
    logic [2:0]  dst_reg;
    logic [3:0]  cond_code;
    logic [7:0]  quick_value;
    logic [2:0]  ext_words;
    logic        is_illegal;
    logic        take_disp;   // target uses extension word
    logic        take_short;  // target uses opcode low byte
  } dec_t;

  // Extension words that one effective address needs.
  function automatic logic [2:0] ea_words(input logic [2:0] mode, input logic [2:0] reg_f,
                                          input logic [1:0] sz);
    logic [2:0] n;
    n = 3'd0;
    if (mode == 3'd5 || mode == 3'd6) n = 3'd1;
    else if (mode == 3'd7) begin
      case (reg_f)
        3'd0, 3'd2, 3'd3: n = 3'd1;
        3'd1:             n = 3'd2;
        3'd4:             n = (sz == SZ_LONG) ? 3'd2 : 3'd1;
        default:          n = 3'd0;
      endcase
    end
    return n;
  endfunction

endpackage

[hdl/m68kd_classify.sv]
// Combinational classification of one opcode word into decoded fields.
module m68kd_classify import m68kd_pkg::*; (
  input  logic [15:0] opcode_i,
  input  logic        xw_dir_i,
  output dec_t        dec_o
);

  logic [2:0] reg9, mode, low, opm;
  logic [1:0] sz;
  logic [2:0] q;
  logic [6:0] mn_t;
  logic       rr_ea;
  logic       rr_ill;
  logic [1:0] arg;

  assign reg9 = opcode_i[11:9];
  assign sz   = opcode_i[7:6];
  assign opm  = opcode_i[8:6];
  assign mode = opcode_i[5:3];
  assign low  = opcode_i[2:0];

  always_comb begin
    dec_t r;
    r = '0;
    r.operand_form = FORM_NONE;
    q = 3'd4;
    mn_t = MN_NONE;
    rr_ea = 1'b0;
    rr_ill = 1'b0;
    arg = 2'd0;
    case (opcode_i[15:12])
      4'h0: begin
        r.operand_form = FORM_PAIR;
        if (opcode_i[8]) begin
          if (mode == 3'd1) begin
            r.mnemonic = MN_MOVEP;
            r.size_code = opcode_i[6] ? SZ_LONG : SZ_WORD;
            r.ext_words = 3'd1;
            if (opcode_i[7]) begin
              r.src_reg = reg9; r.dst_mode = 3'd5; r.dst_reg = low;
            end else begin
              r.src_mode = 3'd5; r.src_reg = low; r.dst_reg = reg9;
            end
          end else begin
            r.mnemonic = MN_BTST + {5'd0, sz};
            r.size_code = (mode != 3'd0) ? SZ_BYTE : SZ_LONG;
            r.src_reg = reg9;
            r.dst_mode = mode; r.dst_reg = low;
            r.ext_words = ea_words(mode, low, r.size_code);
          end
        end else if (reg9 == 3'd4) begin
          r.mnemonic = MN_BTST + {5'd0, sz};
          r.size_code = (mode != 3'd0) ? SZ_BYTE : SZ_LONG;
          r.src_mode = 3'd7; r.src_reg = 3'd4;
          r.dst_mode = mode; r.dst_reg = low;
          r.ext_words = 3'd1 + ea_words(mode, low, r.size_code);
        end else if (sz == 2'd3) begin
          r = '0; r.is_illegal = 1'b1;
        end else if (reg9 == 3'd7) begin
          r.size_code = sz;
          r.mnemonic = MN_MOVES;
          r.ext_words = 3'd1 + ea_words(mode, low, sz);
          if (xw_dir_i) begin
            r.operand_form = FORM_XFIRST; r.dst_mode = mode; r.dst_reg = low;
          end else begin
            r.operand_form = FORM_XLAST; r.src_mode = mode; r.src_reg = low;
          end
        end else begin
          r.size_code = sz;
          case (reg9)
            3'd0: r.mnemonic = MN_ORI;
            3'd1: r.mnemonic = MN_ANDI;
            3'd2: r.mnemonic = MN_SUBI;
            3'd3: r.mnemonic = MN_ADDI;
            3'd5: r.mnemonic = MN_EORI;
            3'd6: r.mnemonic = MN_CMPI;
            default: r.mnemonic = MN_NONE;
          endcase
          r.src_mode = 3'd7; r.src_reg = 3'd4;
          if (opcode_i[5:0] == 6'h3c) begin
            if (sz == SZ_LONG) begin
              r = '0; r.is_illegal = 1'b1;
            end else begin
              r.operand_form = (sz != 2'd0) ? FORM_TO_SR : FORM_TO_CCR;
              r.ext_words = 3'd1;
            end
          end else begin
            r.dst_mode = mode; r.dst_reg = low;
            r.ext_words = ((sz == SZ_LONG) ? 3'd2 : 3'd1) + ea_words(mode, low, sz);
          end
        end
      end
      4'h1, 4'h2, 4'h3: begin
        case (opcode_i[13:12])
          2'd1:    r.size_code = SZ_BYTE;
          2'd2:    r.size_code = SZ_LONG;
          default: r.size_code = SZ_WORD;
        endcase
        r.mnemonic = (opm == 3'd1) ? MN_MOVEA : MN_MOVE;
        r.operand_form = FORM_PAIR;
        r.src_mode = mode; r.src_reg = low;
        r.dst_mode = opm; r.dst_reg = reg9;
        r.ext_words = ea_words(mode, low, r.size_code) +
                      ((opm == 3'd1) ? 3'd0 : ea_words(opm, reg9, r.size_code));
      end
      4'h4: begin
        if (opcode_i[8]) begin
          r.operand_form = FORM_PAIR;
          if (opcode_i[6]) begin
            r.mnemonic = MN_LEA; r.size_code = SZ_LONG; r.dst_mode = 3'd1;
          end else begin
            r.mnemonic = MN_CHK; r.size_code = SZ_WORD;
          end
          r.dst_reg = reg9;
          r.src_mode = mode; r.src_reg = low;
          r.ext_words = ea_words(mode, low, r.size_code);
        end else begin
          r.size_code = SZ_NONE;
          case (reg9)
            3'd0, 3'd1, 3'd2, 3'd3, 3'd5: begin
              if (sz != 2'd3) begin
                case (reg9)
                  3'd0: r.mnemonic = MN_NEGX;
                  3'd1: r.mnemonic = MN_CLR;
                  3'd2: r.mnemonic = MN_NEG;
                  3'd3: r.mnemonic = MN_NOT;
                  default: r.mnemonic = MN_TST;
                endcase
                r.size_code = sz;
                r.operand_form = FORM_DST;
                r.dst_mode = mode; r.dst_reg = low;
                r.ext_words = ea_words(mode, low, sz);
              end else if (reg9 == 3'd5) begin
                if (opcode_i[5:0] == 6'h3c) begin
                  r.mnemonic = MN_ILLEGAL;
                end else begin
                  r.mnemonic = MN_TAS; r.size_code = SZ_BYTE;
                  r.operand_form = FORM_DST;
                  r.dst_mode = mode; r.dst_reg = low;
                  r.ext_words = ea_words(mode, low, SZ_NONE);
                end
              end else begin
                r.mnemonic = MN_MOVE; r.size_code = SZ_WORD;
                if (reg9[2:1] == 2'b00) begin
                  r.operand_form = reg9[0] ? FORM_FROM_CCR : FORM_FROM_SR;
                  r.dst_mode = mode; r.dst_reg = low;
                end else begin
                  r.operand_form = (reg9 == 3'd3) ? FORM_TO_SR : FORM_TO_CCR;
                  r.src_mode = mode; r.src_reg = low;
                end
                r.ext_words = ea_words(mode, low, SZ_NONE);
              end
            end
            3'd4: begin
              r.operand_form = FORM_DST;
              r.dst_mode = mode; r.dst_reg = low;
              if (sz == 2'd0) begin
                r.mnemonic = MN_NBCD; r.size_code = SZ_BYTE;
                r.ext_words = ea_words(mode, low, SZ_BYTE);
              end else if (sz == 2'd1) begin
                if (mode == 3'd0) begin
                  r.mnemonic = MN_SWAP; r.size_code = SZ_WORD;
                end else begin
                  r.mnemonic = MN_PEA; r.size_code = SZ_LONG;
                  r.ext_words = ea_words(mode, low, SZ_LONG);
                end
              end else if (mode == 3'd0) begin
                r.mnemonic = MN_EXT; r.size_code = sz - 2'd1;
              end else begin
                r.mnemonic = MN_MOVEM;
                r.size_code = opcode_i[6] ? SZ_LONG : SZ_WORD;
                r.operand_form = FORM_XFIRST;
                r.ext_words = 3'd1 + ea_words(mode, low, r.size_code);
              end
            end
            3'd6: begin
              r.mnemonic = MN_MOVEM;
              r.size_code = opcode_i[6] ? SZ_LONG : SZ_WORD;
              r.operand_form = FORM_XLAST;
              r.src_mode = mode; r.src_reg = low;
              r.ext_words = 3'd1 + ea_words(mode, low, r.size_code);
            end
            default: begin
              if (sz == 2'd0) begin
                r = '0; r.is_illegal = 1'b1;
              end else if (sz[1]) begin
                r.mnemonic = (sz == 2'd2) ? MN_JSR : MN_JMP;
                r.operand_form = FORM_DST;
                r.dst_mode = mode; r.dst_reg = low;
                r.ext_words = ea_words(mode, low, SZ_LONG);
              end else begin
                case (mode)
                  3'd0, 3'd1: begin
                    r.mnemonic = MN_TRAP; r.operand_form = FORM_QONLY;
                    r.quick_value = {4'd0, opcode_i[3:0]};
                  end
                  3'd2: begin
                    r.mnemonic = MN_LINK; r.operand_form = FORM_PAIR;
                    r.src_mode = 3'd1; r.src_reg = low;
                    r.dst_mode = 3'd7; r.dst_reg = 3'd4; r.ext_words = 3'd1;
                  end
                  3'd3: begin
                    r.mnemonic = MN_UNLK; r.operand_form = FORM_DST;
                    r.dst_mode = 3'd1; r.dst_reg = low;
                  end
                  3'd4: begin
                    r.mnemonic = MN_MOVE; r.size_code = SZ_LONG;
                    r.operand_form = FORM_TO_USP; r.src_mode = 3'd1; r.src_reg = low;
                  end
                  3'd5: begin
                    r.mnemonic = MN_MOVE; r.size_code = SZ_LONG;
                    r.operand_form = FORM_FROM_USP; r.dst_mode = 3'd1; r.dst_reg = low;
                  end
                  3'd6: begin
                    r.mnemonic = MN_RESET + {4'd0, low};
                    // stop and rtd carry an immediate word
                    if (low == 3'd2 || low == 3'd4) begin
                      r.operand_form = FORM_SRC;
                      r.src_mode = 3'd7; r.src_reg = 3'd4; r.ext_words = 3'd1;
                    end
                  end
                  default: begin
                    r.mnemonic = MN_MOVEC; r.size_code = SZ_LONG; r.ext_words = 3'd1;
                    r.operand_form = opcode_i[0] ? FORM_XFIRST : FORM_XLAST;
                  end
                endcase
              end
            end
          endcase
        end
      end
      4'h5: begin
        if (sz == 2'd3) begin
          r.size_code = SZ_NONE;
          r.cond_code = opcode_i[11:8];
          if (mode == 3'd1) begin
            r.mnemonic = MN_DBCC; r.operand_form = FORM_DBR;
            r.src_reg = low; r.ext_words = 3'd1; r.take_disp = 1'b1;
          end else begin
            r.mnemonic = MN_SCC; r.operand_form = FORM_DST;
            r.dst_mode = mode; r.dst_reg = low;
            r.ext_words = ea_words(mode, low, SZ_BYTE);
          end
        end else begin
          r.mnemonic = opcode_i[8] ? MN_SUBQ : MN_ADDQ;
          r.size_code = sz;
          r.operand_form = FORM_QDST;
          r.quick_value = (reg9 != 3'd0) ? {5'd0, reg9} : 8'd8;
          r.dst_mode = mode; r.dst_reg = low;
          r.ext_words = ea_words(mode, low, sz);
        end
      end
      4'h6: begin
        case (opcode_i[11:8])
          4'd0:    r.mnemonic = MN_BRA;
          4'd1:    r.mnemonic = MN_BSR;
          default: r.mnemonic = MN_BCC;
        endcase
        r.size_code = SZ_NONE;
        r.operand_form = FORM_BR;
        r.cond_code = opcode_i[11:8];
        if (opcode_i[7:0] != 8'h00) r.take_short = 1'b1;
        else begin
          r.take_disp = 1'b1; r.ext_words = 3'd1;
        end
      end
      4'h7: begin
        if (opcode_i[8]) begin
          r = '0; r.is_illegal = 1'b1;
        end else begin
          r.mnemonic = MN_MOVEQ; r.size_code = SZ_NONE; r.operand_form = FORM_QDST;
          r.quick_value = opcode_i[7:0];
          r.dst_reg = reg9;
        end
      end
      4'hE: begin
        if (sz == 2'd3) begin
          r.mnemonic = MN_ASR + {4'd0, opcode_i[10:9], 1'b0} + {6'd0, opcode_i[8]};
          r.size_code = SZ_WORD;
          r.operand_form = FORM_DST;
          r.dst_mode = mode; r.dst_reg = low;
          r.ext_words = ea_words(mode, low, SZ_WORD);
        end else begin
          r.mnemonic = MN_ASR + {4'd0, opcode_i[4:3], 1'b0} + {6'd0, opcode_i[8]};
          r.size_code = sz;
          r.dst_reg = low;
          if (opcode_i[5]) begin
            r.operand_form = FORM_PAIR; r.src_reg = reg9;
          end else begin
            r.operand_form = FORM_QDST;
            r.quick_value = (reg9 != 3'd0) ? {5'd0, reg9} : 8'd8;
          end
        end
      end
      4'hA, 4'hF: begin
        r.is_illegal = 1'b1;
      end
      default: begin
        // arithmetic lines 8, 9, B, C, D
        case (opcode_i[15:12])
          4'h8:    q = 3'd0;
          4'h9:    q = 3'd1;
          4'hB:    q = 3'd2;
          4'hC:    q = 3'd3;
          default: q = 3'd4;
        endcase
        if (opm >= 3'd4 && opm <= 3'd6) begin
          if (mode == 3'd0 || mode == 3'd1) begin
            case (q)
              3'd0: begin
                mn_t = MN_SBCD; rr_ill = (opm != 3'd4);
              end
              3'd1: mn_t = MN_SUBX;
              3'd2: begin
                mn_t = MN_CMPM; rr_ea = (mode == 3'd0); arg = 2'd1;
              end
              3'd3: begin
                if (opm == 3'd4) mn_t = MN_ABCD;
                else begin
                  mn_t = MN_EXG;
                  rr_ill = (opm == 3'd6) && (mode == 3'd0);
                  arg = (opm == 3'd5) ? 2'd2 : 2'd3;
                end
              end
              default: mn_t = MN_ADDX;
            endcase
          end else rr_ea = 1'b1;
          if (rr_ill) begin
            r = '0; r.is_illegal = 1'b1;
          end else begin
            r.operand_form = FORM_PAIR;
            r.size_code = sz;
            if (rr_ea) begin
              case (q)
                3'd0: r.mnemonic = MN_OR;
                3'd1: r.mnemonic = MN_SUB;
                3'd2: r.mnemonic = MN_EOR;
                3'd3: r.mnemonic = MN_AND;
                default: r.mnemonic = MN_ADD;
              endcase
              r.src_reg = reg9;
              r.dst_mode = mode; r.dst_reg = low;
              r.ext_words = ea_words(mode, low, sz);
            end else begin
              r.mnemonic = mn_t;
              if (mn_t == MN_EXG) r.size_code = SZ_NONE;
              if (mode == 3'd0) begin
                r.src_reg = low; r.dst_reg = reg9;
              end else begin
                case (arg)
                  2'd0: begin
                    r.src_mode = 3'd4; r.src_reg = low; r.dst_mode = 3'd4; r.dst_reg = reg9;
                  end
                  2'd1: begin
                    r.src_mode = 3'd3; r.src_reg = low; r.dst_mode = 3'd3; r.dst_reg = reg9;
                  end
                  2'd2: begin
                    r.src_mode = 3'd1; r.src_reg = low; r.dst_mode = 3'd1; r.dst_reg = reg9;
                  end
                  default: begin
                    r.src_reg = reg9; r.dst_mode = 3'd1; r.dst_reg = low;
                  end
                endcase
              end
            end
          end
        end else begin
          r.operand_form = FORM_PAIR;
          r.src_mode = mode; r.src_reg = low;
          r.dst_reg = reg9;
          if (opm < 3'd3) begin
            if (mode == 3'd1 && (opm == 3'd0 || q == 3'd0 || q == 3'd3)) begin
              rr_ill = 1'b1;
            end
            r.size_code = sz;
            case (q)
              3'd0: r.mnemonic = MN_OR;
              3'd1: r.mnemonic = MN_SUB;
              3'd2: r.mnemonic = MN_CMP;
              3'd3: r.mnemonic = MN_AND;
              default: r.mnemonic = MN_ADD;
            endcase
          end else begin
            if (q == 3'd0 || q == 3'd3) begin
              rr_ill = (mode == 3'd1);
              r.size_code = SZ_WORD;
            end else begin
              r.dst_mode = 3'd1;
              r.size_code = (opm == 3'd3) ? SZ_WORD : SZ_LONG;
            end
            case (q)
              3'd0: r.mnemonic = (opm == 3'd3) ? MN_DIVU : MN_DIVS;
              3'd1: r.mnemonic = MN_SUBA;
              3'd2: r.mnemonic = MN_CMPA;
              3'd3: r.mnemonic = (opm == 3'd3) ? MN_MULU : MN_MULS;
              default: r.mnemonic = MN_ADDA;
            endcase
          end
          r.ext_words = ea_words(mode, low, r.size_code);
          if (rr_ill) begin
            r = '0; r.is_illegal = 1'b1;
          end
        end
      end
    endcase
    dec_o = r;
  end

endmodule

[hdl/m68k_opcode_decoder_core.sv]
// Top level of the 68000 opcode decoder: input register, decode, result register.
//
// Decodes one 68000 opcode word per clock while the output is not stalled.
// An accepted item is held in an input register, classified and its branch
// target added in one pass of logic, and the result is loaded into the
// output register once that register is empty or not stalled. A new item
// may be accepted every cycle while in_stall_o is low; an output stall backs
// up through the two register stages; in_stall_o rises only when both are full.
module m68k_opcode_decoder_core import m68kd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] instr_addr_i,
  input  logic [15:0] opcode_i,
  input  logic [15:0] ext_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  mnemonic_o,
  output logic [1:0]  size_code_o,
  output logic [3:0]  operand_form_o,
  output logic [2:0]  src_mode_o,
  output logic [2:0]  src_reg_o,
  output logic [2:0]  dst_mode_o,
  output logic [2:0]  dst_reg_o,
  output logic [3:0]  cond_code_o,
  output logic signed [7:0] quick_value_o,
  output logic [2:0]  ext_words_o,
  output logic        is_illegal_o,
  output logic [31:0] branch_target_o
);

  logic        in_vld_q;
  logic [31:0] addr_q;
  logic [15:0] op_q, xw_q;
  logic        out_vld_q;
  dec_t        dec_q;
  logic [31:0] tgt_q;
  dec_t        dec_d;
  logic [31:0] tgt_d, disp;
  logic        out_load, in_load;

  m68kd_classify u_classify (
    .opcode_i (op_q),
    .xw_dir_i (xw_q[11]),
    .dec_o    (dec_d)
  );

  always_comb begin
    disp = '0;
    if (dec_d.take_disp) disp = {{16{xw_q[15]}}, xw_q};
    else if (dec_d.take_short) disp = {{24{op_q[7]}}, op_q[7:0]};
    tgt_d = (dec_d.take_disp || dec_d.take_short) ? addr_q + 32'd2 + disp : 32'd0;
  end

  assign out_load   = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_load    = !in_vld_q || out_load;
  assign in_stall_o = !in_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_load) in_vld_q <= in_valid_i;
      if (out_load) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      addr_q <= instr_addr_i;
      op_q   <= opcode_i;
      xw_q   <= ext_word_i;
    end
    if (out_load) begin
      dec_q <= dec_d;
      tgt_q <= tgt_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign mnemonic_o      = dec_q.mnemonic;
  assign size_code_o     = dec_q.size_code;
  assign operand_form_o  = dec_q.operand_form;
  assign src_mode_o      = dec_q.src_mode;
  assign src_reg_o       = dec_q.src_reg;
  assign dst_mode_o      = dec_q.dst_mode;
  assign dst_reg_o       = dec_q.dst_reg;
  assign cond_code_o     = dec_q.cond_code;
  assign quick_value_o   = dec_q.quick_value;
  assign ext_words_o     = dec_q.ext_words;
  assign is_illegal_o    = dec_q.is_illegal;
  assign branch_target_o = tgt_q;

endmodule
